FILE: rtl/rational_accumulator_alu_top_macros.svh
// Assertion macros shared by the rational accumulator RTL.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef RATIONAL_ACCUMULATOR_ALU_TOP_MACROS_SVH
`define RATIONAL_ACCUMULATOR_ALU_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/raa_pkg.sv
// Shared types, opcodes and command codes for the rational accumulator.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps

package raa_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int SHIFT_BITS = $clog2(WORD_BITS);
  localparam int COUNT_BITS = $clog2(WORD_BITS + 1);

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_READ   = 3'd0;
  localparam opcode_t OP_ADD    = 3'd1;
  localparam opcode_t OP_SUB    = 3'd2;
  localparam opcode_t OP_MUL    = 3'd3;
  localparam opcode_t OP_DIV    = 3'd4;
  localparam opcode_t OP_REDUCE = 3'd5;
  localparam opcode_t OP_LOAD   = 3'd6;

  typedef logic signed [WORD_BITS-1:0]  word_t;
  typedef logic        [WORD_BITS-1:0]  uword_t;
  typedef logic signed [FIELD_BITS-1:0] field_t;

  // Multiplier operand pairs.
  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MS_AN_OD = 2'd0;
  localparam mul_sel_t MS_AD_ON = 2'd1;
  localparam mul_sel_t MS_AD_OD = 2'd2;
  localparam mul_sel_t MS_AN_ON = 2'd3;

  // Source of the holding register.
  typedef logic [1:0] hold_src_t;
  localparam hold_src_t HS_PROD = 2'd0;
  localparam hold_src_t HS_SUM  = 2'd1;
  localparam hold_src_t HS_DIFF = 2'd2;

  // Accumulator update.
  typedef logic [1:0] commit_t;
  localparam commit_t CM_NONE  = 2'd0;
  localparam commit_t CM_ARITH = 2'd1;
  localparam commit_t CM_LOAD  = 2'd2;
  localparam commit_t CM_QUO   = 2'd3;

  typedef struct packed {
    opcode_t opcode;
    field_t  operand_numerator;
    field_t  operand_denominator;
  } item_t;

  typedef struct packed {
    field_t result_numerator;
    field_t result_denominator;
    logic   operand_replaced;
  } result_t;

  typedef struct packed {
    logic      capture;
    logic      gcd_start;
    logic      div_start;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      hold_en;
    hold_src_t hold_src;
    commit_t   commit;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    gcd_done;
    logic    div_done;
    logic    g_zero;
  } dp_sts_t;

endpackage

FILE: rtl/raa_datapath.sv
// Datapath of the rational accumulator: operand capture, shared multiplier,
// binary gcd unit, two restoring dividers and the output register. Uses raa_pkg.
`timescale 1ns / 1ps

module raa_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  raa_pkg::item_t  in_data,
  input  raa_pkg::dp_cmd_t cmd,
  output raa_pkg::dp_sts_t sts,
  output raa_pkg::result_t out_data
);

  import raa_pkg::*;

  typedef struct packed {
    uword_t rem;
    uword_t quo;
  } div_pair_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_pair_t div_step(div_pair_t cur, uword_t d);
    logic [WORD_BITS:0] trial;
    div_pair_t          res;
    trial = {cur.rem, cur.quo[WORD_BITS-1]};
    if (trial >= {1'b0, d}) begin
      res.rem = trial[WORD_BITS-1:0] - d;
      res.quo = {cur.quo[WORD_BITS-2:0], 1'b1};
    end else begin
      res.rem = trial[WORD_BITS-1:0];
      res.quo = {cur.quo[WORD_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

  // Accumulator and captured operand.
  word_t   acc_n_r, acc_n_nxt;
  word_t   acc_d_r, acc_d_nxt;
  opcode_t op_r, op_nxt;
  word_t   on_r, on_nxt;
  word_t   od_r, od_nxt;
  logic    rep_r, rep_nxt;

  // Multiplier and holding register.
  uword_t mul_a, mul_b;
  uword_t mul_full;
  word_t  prod_r, prod_nxt;
  word_t  t_r, t_nxt;

  // Gcd unit.
  logic                  gcd_busy_r, gcd_busy_nxt;
  logic                  gcd_done_r, gcd_done_nxt;
  uword_t                ga_r, ga_nxt;
  uword_t                gb_r, gb_nxt;
  logic [SHIFT_BITS-1:0] gk_r, gk_nxt;
  uword_t                g_r, g_nxt;

  // Dividers.
  logic                  div_busy_r, div_busy_nxt;
  logic                  div_done_r, div_done_nxt;
  logic [COUNT_BITS-1:0] dcnt_r, dcnt_nxt;
  div_pair_t             dn_r, dn_nxt;
  div_pair_t             dd_r, dd_nxt;
  logic                  nneg_r, nneg_nxt;
  logic                  dneg_r, dneg_nxt;

  result_t out_data_r, out_data_nxt;

  word_t  cap_on, cap_od;
  logic   cap_uses, cap_rep;
  uword_t mag_n, mag_d;
  word_t  quo_n, quo_d;

  assign mag_n = acc_n_r[WORD_BITS-1] ? uword_t'(-acc_n_r) : uword_t'(acc_n_r);
  assign mag_d = acc_d_r[WORD_BITS-1] ? uword_t'(-acc_d_r) : uword_t'(acc_d_r);
  assign quo_n = nneg_r ? word_t'(-dn_r.quo) : word_t'(dn_r.quo);
  assign quo_d = dneg_r ? word_t'(-dd_r.quo) : word_t'(dd_r.quo);

  // Operand capture with zero replacement.
  always_comb begin
    cap_on   = word_t'(in_data.operand_numerator);
    cap_od   = word_t'(in_data.operand_denominator);
    cap_uses = (in_data.opcode == OP_ADD) || (in_data.opcode == OP_SUB) ||
               (in_data.opcode == OP_MUL) || (in_data.opcode == OP_DIV) ||
               (in_data.opcode == OP_LOAD);
    cap_rep  = cap_uses && ((cap_od == '0) || ((in_data.opcode == OP_DIV) && (cap_on == '0)));
    op_nxt   = op_r;
    on_nxt   = on_r;
    od_nxt   = od_r;
    rep_nxt  = rep_r;
    if (cmd.capture) begin
      op_nxt  = in_data.opcode;
      on_nxt  = cap_rep ? word_t'(1) : cap_on;
      od_nxt  = cap_rep ? word_t'(1) : cap_od;
      rep_nxt = cap_rep;
    end
  end

  // Shared multiplier; only the low word of the product is kept.
  always_comb begin
    case (cmd.mul_sel)
      MS_AN_OD: begin mul_a = acc_n_r; mul_b = od_r; end
      MS_AD_ON: begin mul_a = acc_d_r; mul_b = on_r; end
      MS_AD_OD: begin mul_a = acc_d_r; mul_b = od_r; end
      default:  begin mul_a = acc_n_r; mul_b = on_r; end
    endcase
    mul_full = mul_a * mul_b;
    prod_nxt = cmd.mul_en ? word_t'(mul_full) : prod_r;
    t_nxt    = t_r;
    if (cmd.hold_en) begin
      case (cmd.hold_src)
        HS_SUM:  t_nxt = t_r + prod_r;
        HS_DIFF: t_nxt = t_r - prod_r;
        default: t_nxt = prod_r;
      endcase
    end
  end

  // Binary gcd on the magnitudes; factors of two common to both are counted in gk.
  always_comb begin
    gcd_busy_nxt = gcd_busy_r;
    gcd_done_nxt = 1'b0;
    ga_nxt       = ga_r;
    gb_nxt       = gb_r;
    gk_nxt       = gk_r;
    g_nxt        = g_r;
    if (cmd.gcd_start) begin
      gcd_busy_nxt = 1'b1;
      ga_nxt       = mag_n;
      gb_nxt       = mag_d;
      gk_nxt       = '0;
    end else if (gcd_busy_r) begin
      if (ga_r == '0) begin
        g_nxt        = gb_r << gk_r;
        gcd_busy_nxt = 1'b0;
        gcd_done_nxt = 1'b1;
      end else if (gb_r == '0) begin
        g_nxt        = ga_r << gk_r;
        gcd_busy_nxt = 1'b0;
        gcd_done_nxt = 1'b1;
      end else if (!ga_r[0] && !gb_r[0]) begin
        ga_nxt = ga_r >> 1;
        gb_nxt = gb_r >> 1;
        gk_nxt = gk_r + 1'b1;
      end else if (!ga_r[0]) begin
        ga_nxt = ga_r >> 1;
      end else if (!gb_r[0]) begin
        gb_nxt = gb_r >> 1;
      end else if (ga_r >= gb_r) begin
        ga_nxt = ga_r - gb_r;
      end else begin
        gb_nxt = gb_r - ga_r;
      end
    end
  end

  // Both parts are divided by the gcd in parallel, one quotient bit per cycle.
  always_comb begin
    div_busy_nxt = div_busy_r;
    div_done_nxt = 1'b0;
    dcnt_nxt     = dcnt_r;
    dn_nxt       = dn_r;
    dd_nxt       = dd_r;
    nneg_nxt     = nneg_r;
    dneg_nxt     = dneg_r;
    if (cmd.div_start) begin
      div_busy_nxt = 1'b1;
      dcnt_nxt     = COUNT_BITS'(WORD_BITS);
      dn_nxt.rem   = '0;
      dn_nxt.quo   = mag_n;
      dd_nxt.rem   = '0;
      dd_nxt.quo   = mag_d;
      nneg_nxt     = acc_n_r[WORD_BITS-1];
      dneg_nxt     = acc_d_r[WORD_BITS-1];
    end else if (div_busy_r) begin
      dn_nxt   = div_step(dn_r, g_r);
      dd_nxt   = div_step(dd_r, g_r);
      dcnt_nxt = dcnt_r - 1'b1;
      if (dcnt_r == COUNT_BITS'(1)) begin
        div_busy_nxt = 1'b0;
        div_done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    acc_n_nxt = acc_n_r;
    acc_d_nxt = acc_d_r;
    case (cmd.commit)
      CM_ARITH: begin acc_n_nxt = t_r;   acc_d_nxt = prod_r; end
      CM_LOAD:  begin acc_n_nxt = on_r;  acc_d_nxt = od_r;   end
      CM_QUO:   begin acc_n_nxt = quo_n; acc_d_nxt = quo_d;  end
      default:  ;
    endcase
    out_data_nxt = out_data_r;
    if (cmd.out_load) begin
      out_data_nxt.result_numerator   = field_t'(acc_n_r);
      out_data_nxt.result_denominator = field_t'(acc_d_r);
      out_data_nxt.operand_replaced   = rep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_n_r    <= '0;
      acc_d_r    <= word_t'(1);
      gcd_busy_r <= 1'b0;
      gcd_done_r <= 1'b0;
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      acc_n_r    <= acc_n_nxt;
      acc_d_r    <= acc_d_nxt;
      gcd_busy_r <= gcd_busy_nxt;
      gcd_done_r <= gcd_done_nxt;
      div_busy_r <= div_busy_nxt;
      div_done_r <= div_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    on_r       <= on_nxt;
    od_r       <= od_nxt;
    rep_r      <= rep_nxt;
    prod_r     <= prod_nxt;
    t_r        <= t_nxt;
    ga_r       <= ga_nxt;
    gb_r       <= gb_nxt;
    gk_r       <= gk_nxt;
    g_r        <= g_nxt;
    dcnt_r     <= dcnt_nxt;
    dn_r       <= dn_nxt;
    dd_r       <= dd_nxt;
    nneg_r     <= nneg_nxt;
    dneg_r     <= dneg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.op       = op_r;
  assign sts.gcd_done = gcd_done_r;
  assign sts.div_done = div_done_r;
  assign sts.g_zero   = (g_r == '0);
  assign out_data     = out_data_r;

endmodule

FILE: rtl/raa_ctrl.sv
// Controller of the rational accumulator: sequences the datapath per opcode
// and owns both handshakes. Uses raa_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "rational_accumulator_alu_top_macros.svh"

module raa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  raa_pkg::opcode_t  in_opcode,
  output logic              out_valid,
  input  logic              out_stall,
  output raa_pkg::dp_cmd_t  cmd,
  input  raa_pkg::dp_sts_t  sts
);

  import raa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL1   = 3'd1;
  localparam logic [2:0] S_MUL2   = 3'd2;
  localparam logic [2:0] S_MUL3   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_GCD    = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (in_opcode) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_nxt = S_MUL1;
            OP_LOAD:                        state_nxt = S_COMMIT;
            OP_REDUCE: begin
              cmd.gcd_start = 1'b1;
              state_nxt     = S_GCD;
            end
            default:                        state_nxt = S_RESULT;
          endcase
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = (sts.op == OP_MUL) ? MS_AN_ON : MS_AN_OD;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.hold_en  = 1'b1;
        cmd.hold_src = HS_PROD;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = (sts.op == OP_MUL) ? MS_AD_OD : MS_AD_ON;
        state_nxt    = ((sts.op == OP_ADD) || (sts.op == OP_SUB)) ? S_MUL3 : S_COMMIT;
      end
      S_MUL3: begin
        cmd.hold_en  = 1'b1;
        cmd.hold_src = (sts.op == OP_SUB) ? HS_DIFF : HS_SUM;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_AD_OD;
        state_nxt    = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = (sts.op == OP_LOAD) ? CM_LOAD : CM_ARITH;
        state_nxt  = S_RESULT;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          if (sts.g_zero) begin
            state_nxt = S_RESULT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.commit = CM_QUO;
          state_nxt  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RAA_ASSERT_IMP(a_out_load_free, cmd.out_load, !out_valid_r || !out_stall, "result loaded over a waiting word")
  `RAA_ASSERT_IMP(a_gcd_done_state, sts.gcd_done, state_r == S_GCD, "gcd finished outside its wait state")
  `RAA_ASSERT_IMP(a_div_done_state, sts.div_done, state_r == S_DIV, "divider finished outside its wait state")
  `RAA_ASSERT_NXT(a_accept_busy, accept, state_r != S_IDLE, "accepted word did not start work")

endmodule

FILE: rtl/rational_accumulator_alu_top.sv
// Top level of the rational accumulator: controller plus datapath.
// Depends on raa_pkg, raa_ctrl and raa_datapath.
//
//   channel | direction | word type | handshake
//   in_     | input     | item_t    | in_valid / in_stall
//   out_    | output    | result_t  | out_valid / out_stall
//
// Read goes straight to the result step; load commits the captured operand; multiply and
// divide pass through the MUL1 and MUL2 steps, add and subtract also through MUL3, before
// the commit. Reduce runs a binary gcd, in which every subtraction is followed by a shift
// that drops a bit, and then, unless the gcd is zero, a one-bit-per-cycle restoring divide
// of both parts by the gcd; the gcd loop and the divider set how long a reduce takes.
// One word is in work at a time; a new word is taken once the previous result sits in
// the output register, even while that result is still stalled.
// Reset is synchronous and active low; it sets the accumulator to 0/1 and empties the
// output register.
`timescale 1ns / 1ps

module rational_accumulator_alu_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  raa_pkg::item_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output raa_pkg::result_t out_data
);

  import raa_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller decides the step sequence from the incoming opcode at accept time
  // and from the captured opcode afterwards.
  raa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the accumulator, the shared multiplier, the gcd unit, the
  // dividers and the output register.
  raa_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
